@@ hdl/swmd_pkg.sv @@
// Package with shared types and constants for the sliding window median block.
package swmd_pkg;
  localparam int ValueLevels = 1024;
  localparam int ValueBits = 10;
  localparam int WindowMax = 256;
  localparam int WinBits = 8;
  localparam int LenBits = 9;
  localparam int IndexBits = 20;
  localparam int CostBits = 18;
  localparam int CountBits = 9;
  localparam int SumBits = 18;
  localparam int TreeBits = 12;
  localparam logic [LenBits-1:0] LenReset = 9'd3;
  localparam logic [0:0] RegWindowLength = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDOLD, ST_REMOVE, ST_ADD, ST_RANK, ST_PREFIX, ST_TOTAL,
    ST_COST, ST_OUT
  } state_t;

  typedef struct packed {
    logic [ValueBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                 window_ready;
    logic [ValueBits-1:0] median;
    logic [CostBits-1:0]  cost;
    logic [CostBits-1:0]  best_cost;
    logic [IndexBits-1:0] best_end;
    logic [ValueBits-1:0] best_median;
  } out_item_t;
endpackage

@@ hdl/swmd_if.sv @@
// Valid/ready channel interfaces for the sliding window median block.
interface swmd_in_if;
  logic valid;
  logic ready;
  swmd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swmd_out_if;
  logic valid;
  logic ready;
  swmd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sliding_window_median_deviation_core.sv @@
// Top level of the sliding window median and deviation cost block.
// With a full window an item passes a window read, two Fenwick update walks, a rank descent
// and two prefix walks on the single-port tree memory. Before the window fills an item needs
// only the add walk. A result waits in the output register while the next item is worked.
// After reset or a window_length write a clearing pass zeroes the trees; no item is accepted
// meanwhile.
module sliding_window_median_deviation_core (
  input  logic             clk,
  input  logic             rst_n,
  swmd_in_if.sink          in_ch,
  swmd_out_if.source       out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [1:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int VB = swmd_pkg::ValueBits;
  localparam int TB = swmd_pkg::TreeBits;
  localparam int CB = swmd_pkg::CountBits;
  localparam int SB = swmd_pkg::SumBits;
  localparam int WB = swmd_pkg::WinBits;
  localparam int LB = swmd_pkg::LenBits;
  localparam int IB = swmd_pkg::IndexBits;
  localparam int KB = swmd_pkg::CostBits;

  logic [CB-1:0] cnt_mem [swmd_pkg::ValueLevels];
  logic [SB-1:0] sum_mem [swmd_pkg::ValueLevels];
  logic [VB-1:0] win_mem [swmd_pkg::WindowMax];

  swmd_pkg::state_t state_r, state_nxt;
  logic [LB-1:0] len_r, len_nxt;
  logic [TB-1:0] x_r, x_nxt;
  logic [TB-1:0] step_r, step_nxt;
  logic          rd_r, rd_nxt;
  logic [VB-1:0] v_r, v_nxt;
  logic [VB-1:0] old_r, old_nxt;
  logic [WB-1:0] wpos_r, wpos_nxt;
  logic [LB-1:0] fill_r, fill_nxt;
  logic [IB-1:0] idx_r, idx_nxt;
  logic [LB-1:0] rem_r, rem_nxt;
  logic [TB-1:0] pos_r, pos_nxt;
  logic [CB-1:0] cl_r, cl_nxt;
  logic [SB-1:0] sl_r, sl_nxt;
  logic [CB-1:0] ct_r, ct_nxt;
  logic [SB-1:0] st_r, st_nxt;
  logic [KB-1:0] bcost_r, bcost_nxt;
  logic [IB-1:0] bend_r, bend_nxt;
  logic [VB-1:0] bmed_r, bmed_nxt;
  logic          ov_r, ov_nxt;
  swmd_pkg::out_item_t od_r, od_nxt;
  logic [KB+VB:0] lo_r, lo_nxt;
  logic [KB+VB:0] hi_r, hi_nxt;

  logic [CB-1:0] cnt_q;
  logic [SB-1:0] sum_q;
  logic [VB-1:0] win_q;
  logic          mem_we;
  logic [VB-1:0] mem_addr;
  logic [CB-1:0] cnt_wd;
  logic [SB-1:0] sum_wd;
  logic          win_we;
  logic [WB-1:0] win_addr;
  logic          cfg_wr;
  logic [LB-1:0] cfg_len;
  logic [TB-1:0] x_low;
  logic [TB-1:0] nx;
  logic [KB-1:0] cost_v;
  logic          full;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-LB){1'b0}}, len_r};
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr == {swmd_pkg::RegWindowLength, 1'b0});
  always_comb begin
    cfg_len = cfg_pwdata[LB-1:0];
    if (cfg_len == '0) begin
      cfg_len = LB'(1);
    end else if (cfg_len > LB'(swmd_pkg::WindowMax)) begin
      cfg_len = LB'(swmd_pkg::WindowMax);
    end
  end

  assign x_low = x_r & (~x_r + TB'(1));
  assign nx = pos_r + step_r;
  assign in_ch.ready = (state_r == swmd_pkg::ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;
  assign cost_v = lo_r[KB-1:0] + hi_r[KB-1:0];
  assign full = (fill_r >= len_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_addr] <= cnt_wd;
      sum_mem[mem_addr] <= sum_wd;
    end
    cnt_q <= cnt_mem[mem_addr];
    sum_q <= sum_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_addr] <= v_nxt;
    end
    win_q <= win_mem[win_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swmd_pkg::ST_CLEAR:  if (x_r == TB'(swmd_pkg::ValueLevels - 1)) begin
        state_nxt = swmd_pkg::ST_IDLE;
      end
      swmd_pkg::ST_IDLE:   if (in_ch.valid && in_ch.ready) begin
        state_nxt = (fill_r >= len_r) ? swmd_pkg::ST_RDOLD : swmd_pkg::ST_ADD;
      end
      swmd_pkg::ST_RDOLD:  if (rd_r) begin
        state_nxt = swmd_pkg::ST_REMOVE;
      end
      swmd_pkg::ST_REMOVE: if (rd_r && (x_r + x_low > TB'(swmd_pkg::ValueLevels))) begin
        state_nxt = swmd_pkg::ST_ADD;
      end
      swmd_pkg::ST_ADD:    if (rd_r && (x_r + x_low > TB'(swmd_pkg::ValueLevels))) begin
        state_nxt = (fill_r >= len_r) ? swmd_pkg::ST_RANK : swmd_pkg::ST_OUT;
      end
      swmd_pkg::ST_RANK:   if (step_r == '0) begin
        state_nxt = swmd_pkg::ST_PREFIX;
      end
      swmd_pkg::ST_PREFIX: if (x_r == '0 && !rd_r) begin
        state_nxt = swmd_pkg::ST_TOTAL;
      end
      swmd_pkg::ST_TOTAL:  if (x_r == '0 && !rd_r) begin
        state_nxt = swmd_pkg::ST_COST;
      end
      swmd_pkg::ST_COST:   state_nxt = swmd_pkg::ST_OUT;
      swmd_pkg::ST_OUT:    if (!ov_r || out_ch.ready) begin
        state_nxt = swmd_pkg::ST_IDLE;
      end
      default:             state_nxt = swmd_pkg::ST_CLEAR;
    endcase
    if (cfg_wr) begin
      state_nxt = swmd_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    len_nxt = len_r; x_nxt = x_r; step_nxt = step_r; rd_nxt = 1'b0;
    v_nxt = v_r; old_nxt = old_r; wpos_nxt = wpos_r; fill_nxt = fill_r;
    idx_nxt = idx_r; rem_nxt = rem_r; pos_nxt = pos_r; cl_nxt = cl_r;
    sl_nxt = sl_r; ct_nxt = ct_r; st_nxt = st_r; bcost_nxt = bcost_r;
    bend_nxt = bend_r; bmed_nxt = bmed_r; ov_nxt = ov_r; od_nxt = od_r;
    lo_nxt = lo_r; hi_nxt = hi_r;
    mem_we = 1'b0; mem_addr = '0; cnt_wd = '0; sum_wd = '0;
    win_we = 1'b0; win_addr = wpos_r - len_r[WB-1:0];
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      swmd_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = x_r[VB-1:0];
        x_nxt = x_r + TB'(1);
      end
      swmd_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          v_nxt = in_ch.data.sample;
          win_we = (fill_r < len_r);
          win_addr = wpos_r;
          if (fill_r < len_r) begin
            wpos_nxt = wpos_r + WB'(1);
            fill_nxt = fill_r + LB'(1);
            x_nxt = TB'(in_ch.data.sample) + TB'(1);
          end
          if (idx_r != '1) begin
            idx_nxt = idx_r + IB'(1);
          end
        end
      end
      swmd_pkg::ST_RDOLD: begin
        rd_nxt = 1'b1;
        if (rd_r) begin
          rd_nxt = 1'b0;
          old_nxt = win_q;
          x_nxt = TB'(win_q) + TB'(1);
          win_we = 1'b1;
          win_addr = wpos_r;
          wpos_nxt = wpos_r + WB'(1);
        end
      end
      swmd_pkg::ST_REMOVE, swmd_pkg::ST_ADD: begin
        mem_addr = VB'(x_r - TB'(1));
        if (!rd_r) begin
          rd_nxt = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (state_r == swmd_pkg::ST_REMOVE) begin
            cnt_wd = cnt_q - CB'(1);
            sum_wd = sum_q - SB'(old_r);
          end else begin
            cnt_wd = cnt_q + CB'(1);
            sum_wd = sum_q + SB'(v_r);
          end
          x_nxt = x_r + x_low;
          if (x_r + x_low > TB'(swmd_pkg::ValueLevels)) begin
            x_nxt = TB'(v_r) + TB'(1);
            step_nxt = TB'(swmd_pkg::ValueLevels);
            pos_nxt = '0;
            rem_nxt = LB'(len_r >> 1) + LB'(1);
          end
        end
      end
      swmd_pkg::ST_RANK: begin
        mem_addr = VB'(nx - TB'(1));
        if (!rd_r) begin
          if (nx > TB'(swmd_pkg::ValueLevels)) begin
            step_nxt = step_r >> 1;
          end else begin
            rd_nxt = 1'b1;
          end
        end else begin
          if (LB'(cnt_q) < rem_r) begin
            pos_nxt = nx;
            rem_nxt = rem_r - LB'(cnt_q);
          end
          step_nxt = step_r >> 1;
        end
        if (step_r == '0) begin
          rd_nxt = 1'b0;
          if (pos_r >= TB'(swmd_pkg::ValueLevels)) begin
            pos_nxt = TB'(swmd_pkg::ValueLevels - 1);
          end
          x_nxt = ((pos_r >= TB'(swmd_pkg::ValueLevels)) ?
                   TB'(swmd_pkg::ValueLevels - 1) : pos_r) + TB'(1);
          cl_nxt = '0; sl_nxt = '0;
        end
      end
      swmd_pkg::ST_PREFIX, swmd_pkg::ST_TOTAL: begin
        mem_addr = VB'(x_r - TB'(1));
        if (!rd_r) begin
          if (x_r != '0) begin
            rd_nxt = 1'b1;
          end else if (state_r == swmd_pkg::ST_PREFIX) begin
            x_nxt = TB'(swmd_pkg::ValueLevels);
            ct_nxt = '0; st_nxt = '0;
          end
        end else begin
          x_nxt = x_r - x_low;
          if (state_r == swmd_pkg::ST_PREFIX) begin
            cl_nxt = cl_r + cnt_q; sl_nxt = sl_r + sum_q;
          end else begin
            ct_nxt = ct_r + cnt_q; st_nxt = st_r + sum_q;
          end
        end
        if (state_r == swmd_pkg::ST_TOTAL && x_r == '0 && !rd_r) begin
          lo_nxt = (KB+VB+1)'(cl_r) * (KB+VB+1)'(pos_r[VB-1:0]) - (KB+VB+1)'(sl_r);
          hi_nxt = (KB+VB+1)'(st_r - sl_r) -
                   (KB+VB+1)'(ct_r - cl_r) * (KB+VB+1)'(pos_r[VB-1:0]);
        end
      end
      swmd_pkg::ST_COST: begin
        if (cost_v < bcost_r) begin
          bcost_nxt = cost_v;
          bend_nxt = idx_r;
          bmed_nxt = pos_r[VB-1:0];
        end
      end
      swmd_pkg::ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          od_nxt.window_ready = full;
          od_nxt.median = full ? pos_r[VB-1:0] : '0;
          od_nxt.cost = full ? cost_v : '0;
          od_nxt.best_cost = bcost_r;
          od_nxt.best_end = bend_r;
          od_nxt.best_median = bmed_r;
        end
      end
      default: begin
      end
    endcase
    if (cfg_wr) begin
      len_nxt = cfg_len; x_nxt = '0; wpos_nxt = '0; fill_nxt = '0; idx_nxt = '0;
      bcost_nxt = '1; bend_nxt = '0; bmed_nxt = '0; ov_nxt = 1'b0; rd_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swmd_pkg::ST_CLEAR;
      len_r <= swmd_pkg::LenReset;
      x_r <= '0; rd_r <= 1'b0; wpos_r <= '0; fill_r <= '0; idx_r <= '0;
      bcost_r <= '1; bend_r <= '0; bmed_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      x_r <= x_nxt; rd_r <= rd_nxt; wpos_r <= wpos_nxt; fill_r <= fill_nxt;
      idx_r <= idx_nxt; bcost_r <= bcost_nxt; bend_r <= bend_nxt;
      bmed_r <= bmed_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt; v_r <= v_nxt; old_r <= old_nxt; rem_r <= rem_nxt;
    pos_r <= pos_nxt; cl_r <= cl_nxt; sl_r <= sl_nxt; ct_r <= ct_nxt;
    st_r <= st_nxt; od_r <= od_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != swmd_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_r) else $error("fill above window length");
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_wr) |-> bcost_r <= $past(bcost_r)) else $error("best rose");
`endif
endmodule
